[rtl/pidr_pkg.sv]
// Package for the PID angle regulator: field widths, register indexes,
// register reset values and angle constants. No dependencies.
`timescale 1ns / 1ps

package pidr_pkg;

	localparam int unsigned ErrW    = 11;
	localparam int unsigned TimeW   = 32;
	localparam int unsigned AngleW  = 14;
	localparam int unsigned PidW    = 15;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgW    = 16;

	localparam logic [AngleW-1:0] CenterAngle = 14'd5120;
	localparam logic [AngleW-1:0] AngleMax    = 14'd10240;

	localparam logic [15:0] PropGainRst     = 16'd819;
	localparam logic [15:0] IntegGainRst    = 16'd8;
	localparam logic [15:0] DerivGainRst    = 16'd40960;
	localparam logic [13:0] OutputLimitRst  = 14'd512;
	localparam logic [14:0] IntegLimitRst   = 15'd500;
	localparam logic [7:0]  DeadBandRst     = 8'd5;
	localparam logic [15:0] StaleTimeRst    = 16'd100;
	localparam logic [15:0] CmdIntervalRst  = 16'd25;

	typedef enum logic [CfgIdxW-1:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INTEG_GAIN_DT  = 3'd1,
		REG_DERIV_GAIN     = 3'd2,
		REG_OUTPUT_LIMIT   = 3'd3,
		REG_INTEGRAL_LIMIT = 3'd4,
		REG_DEAD_BAND      = 3'd5,
		REG_STALE_TIME     = 3'd6,
		REG_CMD_INTERVAL   = 3'd7
	} cfg_reg_t;

endpackage

[rtl/pidr_in_if.sv]
// Request channel of the PID angle regulator: valid/ready and the input fields.
// Depends on pidr_pkg for the field widths.
`timescale 1ns / 1ps

interface pidr_in_if;
	import pidr_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [ErrW-1:0]  error_pixels;
	logic [TimeW-1:0]        now_ms;
	logic [TimeW-1:0]        frame_time_ms;

	modport source (output valid, output error_pixels, output now_ms,
		output frame_time_ms, input ready);
	modport sink (input valid, input error_pixels, input now_ms,
		input frame_time_ms, output ready);
endinterface

[rtl/pidr_out_if.sv]
// Result channel of the PID angle regulator: valid/ready and the result fields.
// Depends on pidr_pkg for the field widths.
`timescale 1ns / 1ps

interface pidr_out_if;
	import pidr_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   command_valid;
	logic [AngleW-1:0]      set_angle;
	logic signed [PidW-1:0] pid_output;
	logic                   frozen;

	modport source (output valid, output command_valid, output set_angle,
		output pid_output, output frozen, input ready);
	modport sink (input valid, input command_valid, input set_angle,
		input pid_output, input frozen, output ready);
endinterface

[rtl/pid_angle_regulator_core.sv]
// PID angle regulator top level: configuration registers, input stage,
// PID arithmetic with anti-windup, rate limit, deadband and result register.
// Depends on pidr_pkg, pidr_in_if and pidr_out_if.
`timescale 1ns / 1ps

// Usage:
// One request per control tick arrives on the request channel (error in
// pixels, current time and last frame time); one result leaves on the result
// channel for every request. Both channels use valid/ready and move a request
// at a clock edge where both are high.
// A request is captured into an input register; the PID sum, clamps, state
// update and command gating are computed from it combinationally, and the
// result is registered in an output register, from which it leaves when the
// receiver is ready.
// Throughput is one request per cycle while the receiver is ready; the loop
// state (error sum, previous error, last command time) is written as a result
// enters the output register, so the next request sees it in the following cycle.
// When the receiver stalls, the output register holds its result and the input
// register holds one more request; ready drops only when both are full and the
// receiver is not ready. Configuration is written through cfg_wr_en/cfg_index/
// cfg_data and should only change while no request is in flight.
// Reset clears the loop state, empties both registers and loads the default
// gains and limits.
module pid_angle_regulator_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [pidr_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [pidr_pkg::CfgW-1:0]    cfg_data,
	pidr_in_if.sink                      request,
	pidr_out_if.source                   result
);
	import pidr_pkg::*;

	// Configuration registers.
	logic [15:0] prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [13:0] output_limit_q;
	logic [14:0] integral_limit_q;
	logic [7:0]  dead_band_q;
	logic [15:0] stale_time_q, cmd_gap_q;

	// Loop state.
	logic signed [15:0] error_sum_q;
	logic signed [11:0] prev_error_q;
	logic [TimeW-1:0]   last_cmd_q;

	// Input stage.
	logic                   valid_s1;
	logic signed [ErrW-1:0] error_s1;
	logic [TimeW-1:0]       now_s1, frame_s1;

	// Output stage.
	logic                   valid_s2;
	logic                   cmd_valid_s2;
	logic [AngleW-1:0]      target_s2;
	logic signed [PidW-1:0] pid_s2;
	logic                   frozen_s2;

	logic advance;

	assign advance       = valid_s1 && (!valid_s2 || result.ready);
	assign request.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= PropGainRst;
			integ_gain_q     <= IntegGainRst;
			deriv_gain_q     <= DerivGainRst;
			output_limit_q   <= OutputLimitRst;
			integral_limit_q <= IntegLimitRst;
			dead_band_q      <= DeadBandRst;
			stale_time_q     <= StaleTimeRst;
			cmd_gap_q        <= CmdIntervalRst;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:      prop_gain_q      <= cfg_data;
				REG_INTEG_GAIN_DT:  integ_gain_q     <= cfg_data;
				REG_DERIV_GAIN:     deriv_gain_q     <= cfg_data;
				REG_OUTPUT_LIMIT:   output_limit_q   <= cfg_data[13:0];
				REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[14:0];
				REG_DEAD_BAND:      dead_band_q      <= cfg_data[7:0];
				REG_STALE_TIME:     stale_time_q     <= cfg_data;
				REG_CMD_INTERVAL:   cmd_gap_q        <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			error_s1 <= request.error_pixels;
			now_s1   <= request.now_ms;
			frame_s1 <= request.frame_time_ms;
		end
	end

	// PID arithmetic on the request in the input register.
	logic [TimeW-1:0]    frame_age, since_cmd;
	logic                stale, cmd_due;
	logic signed [11:0]  err;
	logic signed [12:0]  err_diff;
	logic signed [16:0]  kp_s, ki_s, kd_s;
	logic signed [28:0]  p_prod;
	logic signed [32:0]  i_prod;
	logic signed [29:0]  d_prod;
	logic signed [34:0]  acc;
	logic signed [30:0]  pid_raw, lim_w;
	logic signed [14:0]  pid, lim;
	logic                sat_hi, sat_lo;
	logic signed [16:0]  sum_raw, ilim;
	logic signed [15:0]  sum_next;
	logic [14:0]         pid_mag;
	logic signed [15:0]  target_raw;
	logic [AngleW-1:0]   target;
	logic                issue;

	always_comb begin
		frame_age = now_s1 - frame_s1;
		stale     = frame_age > {16'b0, stale_time_q};
		since_cmd = now_s1 - last_cmd_q;
		cmd_due   = since_cmd >= {16'b0, cmd_gap_q};

		err      = -($signed({error_s1[ErrW-1], error_s1}));
		err_diff = 13'(err) - 13'(prev_error_q);

		kp_s   = $signed({1'b0, prop_gain_q});
		ki_s   = $signed({1'b0, integ_gain_q});
		kd_s   = $signed({1'b0, deriv_gain_q});
		p_prod = kp_s * err;
		i_prod = ki_s * error_sum_q;
		d_prod = kd_s * err_diff;
		acc    = 35'(p_prod) + 35'(i_prod) + 35'(d_prod);

		// An arithmetic shift by four is floor division by 16.
		pid_raw = acc[34:4];
		lim_w   = $signed({17'b0, output_limit_q});
		lim     = $signed({1'b0, output_limit_q});
		if (pid_raw > lim_w) begin
			pid = lim;
		end else if (pid_raw < -lim_w) begin
			pid = -lim;
		end else begin
			pid = pid_raw[14:0];
		end

		// Anti-windup: hold the sum while the output is pinned in the error's direction.
		sat_hi  = (pid >= lim) && (err > 12'sd0);
		sat_lo  = (pid <= -lim) && (err < 12'sd0);
		sum_raw = 17'(error_sum_q) + 17'(err);
		ilim    = $signed({2'b0, integral_limit_q});
		if (sum_raw > ilim) begin
			sum_next = ilim[15:0];
		end else if (sum_raw < -ilim) begin
			sum_next = 16'(-ilim);
		end else begin
			sum_next = sum_raw[15:0];
		end

		pid_mag    = pid[14] ? 15'(-pid) : pid;
		target_raw = $signed({2'b0, CenterAngle}) + 16'(pid);
		if (target_raw < 16'sd0) begin
			target = '0;
		end else if (target_raw > $signed({2'b0, AngleMax})) begin
			target = AngleMax;
		end else begin
			target = target_raw[AngleW-1:0];
		end
		issue = cmd_due && (pid_mag >= {7'b0, dead_band_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			prev_error_q <= '0;
			last_cmd_q   <= '0;
		end else if (advance) begin
			if (stale) begin
				error_sum_q  <= '0;
				prev_error_q <= '0;
			end else begin
				if (!sat_hi && !sat_lo) begin
					error_sum_q <= sum_next;
				end
				prev_error_q <= err;
				if (cmd_due) begin
					last_cmd_q <= now_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frozen_s2    <= stale;
			cmd_valid_s2 <= !stale && issue;
			target_s2    <= (!stale && issue) ? target : '0;
			pid_s2       <= stale ? '0 : pid;
		end
	end

	assign result.valid         = valid_s2;
	assign result.command_valid = cmd_valid_s2;
	assign result.set_angle     = target_s2;
	assign result.pid_output    = pid_s2;
	assign result.frozen        = frozen_s2;

endmodule
